>>> rtl/core/satlb_pkg.sv
package satlb_pkg;

    localparam int VPN_W       = 20;
    localparam int PPN_W       = 20;
    localparam int WAY_IDX_W   = 4;
    localparam int RECIP_SHIFT = 32;

    localparam int DEF_SETS    = 16;
    localparam int DEF_WAYS    = 4;

    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> rtl/core/satlb_front.sv
module satlb_front #(
    parameter int SETS = satlb_pkg::DEF_SETS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hold,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [satlb_pkg::VPN_W-1:0] i_vpn,
    input  logic                        i_write,
    input  logic [satlb_pkg::PPN_W-1:0] i_fill_ppn,
    input  logic                        i_pte_dirty,
    input  logic                        i_q_full,
    output logic                        o_push,
    output logic                        o_opcode,
    output logic                        o_write,
    output logic                        o_pte_dirty,
    output logic [satlb_pkg::PPN_W-1:0] o_fill_ppn,
    output logic [satlb_pkg::idx_width(SETS)-1:0] o_set,
    output logic [$clog2(((2**satlb_pkg::VPN_W)-1)/SETS+1)-1:0] o_tag
);

    localparam int VPN_W   = satlb_pkg::VPN_W;
    localparam int SHIFT   = satlb_pkg::RECIP_SHIFT;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = VPN_W + RECIP_W;
    localparam int SET_W   = satlb_pkg::idx_width(SETS);
    localparam int TAG_W   = $clog2(((2**VPN_W)-1)/SETS+1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / SETS);
    localparam logic [VPN_W-1:0]   SETS_V = VPN_W'(SETS);

    logic                   r_valid;
    logic                   r_opcode;
    logic                   r_write;
    logic                   r_pte_dirty;
    logic [VPN_W-1:0]       r_vpn;
    logic [satlb_pkg::PPN_W-1:0] r_fill_ppn;
    logic [PROD_W-1:0]      r_prod;

    logic                   accept;
    logic [VPN_W-1:0]       quot_est;
    logic [VPN_W-1:0]       quot;
    logic [VPN_W-1:0]       rem_est;
    logic [VPN_W-1:0]       rem;

    assign o_in_stall = i_hold || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    // The reciprocal estimate of the quotient is at most one short.
    always_comb begin
        quot_est = r_prod[SHIFT +: VPN_W];
        rem_est  = r_vpn - VPN_W'(quot_est * SETS_V);
        if (rem_est >= SETS_V) begin
            rem  = rem_est - SETS_V;
            quot = quot_est + VPN_W'(1);
        end else begin
            rem  = rem_est;
            quot = quot_est;
        end
    end

    assign o_opcode    = r_opcode;
    assign o_write     = r_write;
    assign o_pte_dirty = r_pte_dirty;
    assign o_fill_ppn  = r_fill_ppn;
    assign o_set       = SET_W'(rem);
    assign o_tag       = TAG_W'(quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode    <= i_opcode;
            r_write     <= i_write;
            r_pte_dirty <= i_pte_dirty;
            r_vpn       <= i_vpn;
            r_fill_ppn  <= i_fill_ppn;
            r_prod      <= PROD_W'(i_vpn * RECIP);
        end
    end

endmodule

>>> rtl/core/satlb_queue.sv
module satlb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = satlb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = satlb_pkg::idx_width(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/satlb_back.sv
module satlb_back #(
    parameter int SETS = satlb_pkg::DEF_SETS,
    parameter int WAYS = satlb_pkg::DEF_WAYS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    output logic                        o_clearing,
    input  logic                        i_q_valid,
    output logic                        o_pop,
    input  logic                        i_opcode,
    input  logic                        i_write,
    input  logic                        i_pte_dirty,
    input  logic [satlb_pkg::PPN_W-1:0] i_fill_ppn,
    input  logic [satlb_pkg::idx_width(SETS)-1:0] i_set,
    input  logic [$clog2(((2**satlb_pkg::VPN_W)-1)/SETS+1)-1:0] i_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [satlb_pkg::PPN_W-1:0] o_result_ppn,
    output logic                        o_dirty_out,
    output logic                        o_mark_pte_dirty,
    output logic                        o_replaced_valid,
    output logic [satlb_pkg::WAY_IDX_W-1:0] o_way_used
);

    localparam int PPN_W  = satlb_pkg::PPN_W;
    localparam int SET_W  = satlb_pkg::idx_width(SETS);
    localparam int TAG_W  = $clog2(((2**satlb_pkg::VPN_W)-1)/SETS+1);
    localparam int WAY_W  = satlb_pkg::idx_width(WAYS);
    localparam int RANK_W = satlb_pkg::idx_width(WAYS);
    localparam int ROW_W  = 2 + RANK_W + TAG_W + PPN_W;
    localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(WAYS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [SET_W-1:0] r_clr;

    logic             r_opcode;
    logic             r_write;
    logic             r_pte_dirty;
    logic [PPN_W-1:0] r_fill_ppn;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    logic             r_o_valid;
    logic             r_hit;
    logic [PPN_W-1:0] r_ppn;
    logic             r_dirty;
    logic             r_mark;
    logic             r_repl;
    logic [satlb_pkg::WAY_IDX_W-1:0] r_way;

    logic             rd_en;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] rd_row [WAYS];
    logic [ROW_W-1:0] wr_row [WAYS];

    logic             rd_valid [WAYS];
    logic             rd_dirty [WAYS];
    logic [RANK_W-1:0] rd_rank [WAYS];
    logic [TAG_W-1:0] rd_tag   [WAYS];
    logic [PPN_W-1:0] rd_ppn   [WAYS];

    logic             found;
    logic             have_free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] old_way;
    logic [WAY_W-1:0] sel_way;
    logic             is_fill;
    logic             new_fill;
    logic             touch;
    logic             out_free;
    logic             do_look;
    logic [RANK_W-1:0] sel_rank;
    logic [PPN_W-1:0] res_ppn;
    logic             res_dirty;

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign rd_en      = o_pop;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign do_look    = (r_state == ST_LOOK) && out_free;

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        logic [ROW_W-1:0] r_mem [SETS];
        logic [ROW_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr] <= wr_row[w];
            end
            if (rd_en) begin
                r_rd <= r_mem[i_set];
            end
        end

        assign rd_row[w] = r_rd;
        assign {rd_valid[w], rd_dirty[w], rd_rank[w], rd_tag[w], rd_ppn[w]} = r_rd;
    end

    // Way selection: first matching way, else lowest empty way, else the oldest.
    always_comb begin
        found     = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        old_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_valid[w] && rd_tag[w] == r_tag) begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!rd_valid[w]) begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
            if (rd_rank[w] == '0) begin
                old_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        is_fill  = (r_opcode == satlb_pkg::OP_FILL);
        new_fill = is_fill && !found;
        touch    = found || is_fill;
        if (found) begin
            sel_way = hit_way;
        end else if (have_free) begin
            sel_way = free_way;
        end else begin
            sel_way = old_way;
        end
        sel_rank = rd_rank[sel_way];
        if (found) begin
            res_ppn   = rd_ppn[hit_way];
            res_dirty = rd_dirty[hit_way] | (is_fill & r_write);
        end else begin
            res_ppn   = r_fill_ppn;
            res_dirty = r_write | r_pte_dirty;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_set;
        for (int w = 0; w < WAYS; w++) begin
            wr_row[w] = rd_row[w];
        end
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            for (int w = 0; w < WAYS; w++) begin
                wr_row[w] = '0;
            end
        end else if (do_look && touch) begin
            wr_en = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                if (WAY_W'(w) == sel_way) begin
                    if (found) begin
                        wr_row[w] = {1'b1, res_dirty, TOP_RANK, rd_tag[w], rd_ppn[w]};
                    end else begin
                        wr_row[w] = {1'b1, res_dirty, TOP_RANK, r_tag, r_fill_ppn};
                    end
                end else if (rd_rank[w] > sel_rank) begin
                    wr_row[w] = {rd_valid[w], rd_dirty[w], rd_rank[w] - RANK_W'(1),
                                 rd_tag[w], rd_ppn[w]};
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (do_look) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_opcode    <= i_opcode;
            r_write     <= i_write;
            r_pte_dirty <= i_pte_dirty;
            r_fill_ppn  <= i_fill_ppn;
            r_set       <= i_set;
            r_tag       <= i_tag;
        end
        if (do_look) begin
            r_hit  <= found;
            r_ppn  <= touch ? res_ppn : '0;
            r_dirty <= touch ? res_dirty : 1'b0;
            r_mark <= new_fill && r_write && !r_pte_dirty;
            r_repl <= new_fill && !have_free;
            r_way  <= touch ? satlb_pkg::WAY_IDX_W'(sel_way) : '0;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_hit            = r_hit;
    assign o_result_ppn     = r_ppn;
    assign o_dirty_out      = r_dirty;
    assign o_mark_pte_dirty = r_mark;
    assign o_replaced_valid = r_repl;
    assign o_way_used       = r_way;

endmodule

>>> rtl/core/set_assoc_tlb_lru.sv
// Set-associative TLB with LRU replacement. Each beat is a lookup or a fill; every beat
// gives exactly one result beat, in order. After reset the block holds o_in_stall high
// while it clears its way memories. A beat is then split into set and tag in the front
// stage and passes a four-entry queue to the back end, which reads the set from the way
// memories when it pops the beat and compares, updates recency and writes back in its
// look state; the back end takes no new beat until that read-then-write of the set memory
// is done, and this sets the rate. An accepted beat is registered in the front stage,
// written into the queue, read from the way memories and registered at the output.
module set_assoc_tlb_lru #(
    parameter int SETS = satlb_pkg::DEF_SETS,
    parameter int WAYS = satlb_pkg::DEF_WAYS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [satlb_pkg::VPN_W-1:0] i_vpn,
    input  logic                        i_write,
    input  logic [satlb_pkg::PPN_W-1:0] i_fill_ppn,
    input  logic                        i_pte_dirty,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [satlb_pkg::PPN_W-1:0] o_result_ppn,
    output logic                        o_dirty_out,
    output logic                        o_mark_pte_dirty,
    output logic                        o_replaced_valid,
    output logic [satlb_pkg::WAY_IDX_W-1:0] o_way_used
);

    localparam int PPN_W = satlb_pkg::PPN_W;
    localparam int SET_W = satlb_pkg::idx_width(SETS);
    localparam int TAG_W = $clog2(((2**satlb_pkg::VPN_W)-1)/SETS+1);
    localparam int Q_W   = 3 + PPN_W + SET_W + TAG_W;

    logic             clearing;
    logic             q_full;
    logic             q_valid;
    logic             push;
    logic             pop;
    logic [Q_W-1:0]   q_in;
    logic [Q_W-1:0]   q_out;

    logic             f_opcode;
    logic             f_write;
    logic             f_pte_dirty;
    logic [PPN_W-1:0] f_fill_ppn;
    logic [SET_W-1:0] f_set;
    logic [TAG_W-1:0] f_tag;

    logic             b_opcode;
    logic             b_write;
    logic             b_pte_dirty;
    logic [PPN_W-1:0] b_fill_ppn;
    logic [SET_W-1:0] b_set;
    logic [TAG_W-1:0] b_tag;

    satlb_front #(.SETS(SETS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_vpn       (i_vpn),
        .i_write     (i_write),
        .i_fill_ppn  (i_fill_ppn),
        .i_pte_dirty (i_pte_dirty),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_opcode    (f_opcode),
        .o_write     (f_write),
        .o_pte_dirty (f_pte_dirty),
        .o_fill_ppn  (f_fill_ppn),
        .o_set       (f_set),
        .o_tag       (f_tag)
    );

    assign q_in = {f_opcode, f_write, f_pte_dirty, f_fill_ppn, f_set, f_tag};

    satlb_queue #(.WIDTH(Q_W), .DEPTH(satlb_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_opcode, b_write, b_pte_dirty, b_fill_ppn, b_set, b_tag} = q_out;

    satlb_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .o_clearing       (clearing),
        .i_q_valid        (q_valid),
        .o_pop            (pop),
        .i_opcode         (b_opcode),
        .i_write          (b_write),
        .i_pte_dirty      (b_pte_dirty),
        .i_fill_ppn       (b_fill_ppn),
        .i_set            (b_set),
        .i_tag            (b_tag),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_result_ppn     (o_result_ppn),
        .o_dirty_out      (o_dirty_out),
        .o_mark_pte_dirty (o_mark_pte_dirty),
        .o_replaced_valid (o_replaced_valid),
        .o_way_used       (o_way_used)
    );

endmodule

>>> verif/set_assoc_tlb_lru_tb.sv
`timescale 1ns / 100ps

module set_assoc_tlb_lru_tb;

    localparam int VPN_W = satlb_pkg::VPN_W;
    localparam int PPN_W = satlb_pkg::PPN_W;
    localparam int WAY_IDX_W = satlb_pkg::WAY_IDX_W;
    localparam logic OP_LOOKUP = satlb_pkg::OP_LOOKUP;
    localparam logic OP_FILL = satlb_pkg::OP_FILL;
    localparam int NSETS = satlb_pkg::DEF_SETS;
    localparam int NWAYS = satlb_pkg::DEF_WAYS;
    localparam int WD_LIMIT = 2000;

    typedef struct packed {
        logic             opcode;
        logic [VPN_W-1:0] vpn;
        logic             write;
        logic [PPN_W-1:0] fill_ppn;
        logic             pte_dirty;
    } t_tlb_req;

    typedef struct packed {
        logic                 hit;
        logic [PPN_W-1:0]     ppn;
        logic                 dirty;
        logic                 mark_dirty;
        logic                 replaced;
        logic [WAY_IDX_W-1:0] way;
    } t_tlb_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_opcode = OP_LOOKUP;
    logic [VPN_W-1:0] i_vpn = '0;
    logic i_write = 1'b0;
    logic [PPN_W-1:0] i_fill_ppn = '0;
    logic i_pte_dirty = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_hit;
    logic [PPN_W-1:0] o_result_ppn;
    logic o_dirty_out;
    logic o_mark_pte_dirty;
    logic o_replaced_valid;
    logic [WAY_IDX_W-1:0] o_way_used;

    set_assoc_tlb_lru dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the translation entries.
    logic                 tlb_valid [NSETS][NWAYS];
    logic [15:0]          tlb_tag   [NSETS][NWAYS];
    logic [PPN_W-1:0]     tlb_ppn   [NSETS][NWAYS];
    logic                 tlb_dirty [NSETS][NWAYS];
    int                   tlb_rank  [NSETS][NWAYS];

    t_tlb_req  pending_reqs[$];
    t_tlb_resp expected_resps[$];
    int        fail_count = 0;
    bit        hold_sender = 1'b0;
    bit        quiet = 1'b0;

    function automatic void promote_way(input int s, input int w);
        int r;
        r = tlb_rank[s][w];
        for (int i = 0; i < NWAYS; i++)
            if (i != w && tlb_rank[s][i] > r) tlb_rank[s][i]--;
        tlb_rank[s][w] = NWAYS - 1;
    endfunction

    function automatic t_tlb_resp translate(input t_tlb_req rq);
        t_tlb_resp rs;
        int s, w;
        logic [15:0] tg;
        bit found;
        rs = '0;
        s = rq.vpn % NSETS;
        tg = 16'(rq.vpn / NSETS);
        found = 1'b0;
        w = 0;
        for (int i = 0; i < NWAYS; i++)
            if (!found && tlb_valid[s][i] && tlb_tag[s][i] == tg) begin
                found = 1'b1;
                w = i;
            end
        if (found) begin
            promote_way(s, w);
            if (rq.opcode == OP_FILL) tlb_dirty[s][w] = tlb_dirty[s][w] | rq.write;
            rs.hit = 1'b1;
            rs.ppn = tlb_ppn[s][w];
            rs.dirty = tlb_dirty[s][w];
            rs.way = WAY_IDX_W'(w);
            return rs;
        end
        if (rq.opcode == OP_LOOKUP) return rs;
        found = 1'b0;
        for (int i = 0; i < NWAYS; i++)
            if (!found && !tlb_valid[s][i]) begin
                found = 1'b1;
                w = i;
            end
        if (!found) begin
            w = 0;
            for (int i = NWAYS - 1; i >= 0; i--)
                if (tlb_rank[s][i] == 0) w = i;
            rs.replaced = 1'b1;
        end
        tlb_valid[s][w] = 1'b1;
        tlb_tag[s][w] = tg;
        tlb_ppn[s][w] = rq.fill_ppn;
        tlb_dirty[s][w] = rq.write | rq.pte_dirty;
        promote_way(s, w);
        rs.ppn = rq.fill_ppn;
        rs.dirty = rq.write | rq.pte_dirty;
        rs.mark_dirty = rq.write & ~rq.pte_dirty;
        rs.way = WAY_IDX_W'(w);
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // Sender: bursts of idle, otherwise the next queued beat.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_resps.push_back(translate(pending_reqs.pop_front()));
                if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
            end else if (!i_in_valid && send_gap > 0) begin
                send_gap--;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_reqs.size() > 0 && send_gap == 0 && !hold_sender) begin
                    t_tlb_req nx;
                    nx = pending_reqs[0];
                    i_in_valid <= 1'b1;
                    i_opcode <= nx.opcode;
                    i_vpn <= nx.vpn;
                    i_write <= nx.write;
                    i_fill_ppn <= nx.fill_ppn;
                    i_pte_dirty <= nx.pte_dirty;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, checks each result beat.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    t_tlb_resp ex;
                    ex = expected_resps.pop_front();
                    if (o_hit !== ex.hit) report_mismatch("hit", o_hit, ex.hit);
                    if (o_result_ppn !== ex.ppn) report_mismatch("ppn", o_result_ppn, ex.ppn);
                    if (o_dirty_out !== ex.dirty) report_mismatch("dirty", o_dirty_out, ex.dirty);
                    if (o_mark_pte_dirty !== ex.mark_dirty)
                        report_mismatch("mark_pte_dirty", o_mark_pte_dirty, ex.mark_dirty);
                    if (o_replaced_valid !== ex.replaced)
                        report_mismatch("replaced_valid", o_replaced_valid, ex.replaced);
                    if (o_way_used !== ex.way) report_mismatch("way_used", o_way_used, ex.way);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= (stall_left > 0);
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 17);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_tlb_req mk_req(input logic op, input logic [VPN_W-1:0] v,
                                        input logic wr, input logic [PPN_W-1:0] p,
                                        input logic pd);
        t_tlb_req rq;
        rq.opcode = op;
        rq.vpn = v;
        rq.write = wr;
        rq.fill_ppn = p;
        rq.pte_dirty = pd;
        return rq;
    endfunction

    function automatic t_tlb_req rand_req(input logic [VPN_W-1:0] v);
        return mk_req(1'($urandom_range(0, 1)), v, 1'($urandom_range(0, 1)),
                      PPN_W'($urandom()), 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        logic [VPN_W-1:0] hot [$];
        logic [VPN_W-1:0] v;
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++) begin
                tlb_valid[s][w] = 1'b0;
                tlb_dirty[s][w] = 1'b0;
                tlb_rank[s][w] = 0;
                tlb_tag[s][w] = '0;
                tlb_ppn[s][w] = '0;
            end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: misses, first fills, tag-present fills, eviction in set 3.
        pending_reqs.push_back(mk_req(OP_LOOKUP, '0, 1'b0, '0, 1'b0));
        pending_reqs.push_back(mk_req(OP_FILL, '0, 1'b1, '0, 1'b0));
        pending_reqs.push_back(mk_req(OP_LOOKUP, '0, 1'b1, '1, 1'b1));
        pending_reqs.push_back(mk_req(OP_FILL, 20'hFFFFF, 1'b0, '1, 1'b0));
        pending_reqs.push_back(mk_req(OP_FILL, 20'hFFFFF, 1'b1, 20'h12345, 1'b1));
        pending_reqs.push_back(mk_req(OP_LOOKUP, 20'hFFFFF, 1'b0, '0, 1'b0));
        for (int k = 0; k < 5; k++)
            pending_reqs.push_back(mk_req(OP_FILL, VPN_W'(20'h3 + k * NSETS), k[0],
                                          PPN_W'(20'hA0000 + k), k[1]));
        pending_reqs.push_back(mk_req(OP_LOOKUP, 20'h13, 1'b0, '0, 1'b0));
        pending_reqs.push_back(mk_req(OP_FILL, 20'h53, 1'b0, '0, 1'b1));
        pending_reqs.push_back(mk_req(OP_FILL, 20'hFFFF3, 1'b1, 20'h55555, 1'b0));
        pending_reqs.push_back(mk_req(OP_LOOKUP, 20'h3, 1'b0, '0, 1'b0));
        pending_reqs.push_back(mk_req(OP_LOOKUP, 20'hFFFF3, 1'b0, '0, 1'b0));
        wait (pending_reqs.size() == 0 && expected_resps.size() == 0);

        // A pause of the sender once everything has drained.
        hold_sender = 1'b1;
        repeat (5) @(posedge i_clk);
        hold_sender = 1'b0;

        // Random: a small pool of hot pages so that sets fill, hit and evict.
        for (int k = 0; k < 24; k++) hot.push_back(VPN_W'($urandom()));
        for (int k = 0; k < 950; k++) begin
            if ($urandom_range(0, 4) == 0) v = VPN_W'($urandom());
            else v = hot[$urandom_range(0, hot.size() - 1)];
            if ($urandom_range(0, 29) == 0)
                hot[$urandom_range(0, hot.size() - 1)] = VPN_W'($urandom());
            pending_reqs.push_back(rand_req(v));
            if (k == 800) begin
                wait (pending_reqs.size() < 10);
                quiet = 1'b1;
            end
        end
        wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_resps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
